>>> hw/rtl/cbd_pkg.sv
// package for the chunked body deframer
// shared types, register indexes, byte codes and default sizes; no dependencies
package cbd_pkg;

  // register indexes of the configuration port
  localparam logic CFG_MAX_CHUNK = 1'b0;
  localparam logic CFG_EMIT      = 1'b1;

  localparam logic [31:0] MAX_CHUNK_RESET = 32'd65536;

  // default sizes
  localparam int unsigned COUNT_BITS_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // character codes
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_SEMI = 8'd59;

  // configuration seen by the back end
  typedef struct packed {
    logic [31:0] max_chunk;
    logic        emit_payload;
  } cfg_t;

  // one classified body byte, as handed from front to back
  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_byte;
    logic       end_of_data;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
  } cls_t;

  // one result request
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [2:0]  status;
    logic [31:0] raw_count;
    logic [31:0] decoded_count;
  } res_t;

  localparam int unsigned CLS_BITS = $bits(cls_t);
  localparam int unsigned RES_BITS = $bits(res_t);

endpackage

>>> hw/rtl/cbd_fifo.sv
// small flip-flop queue used between the deframer stages
// generic width and depth; no dependencies
module cbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/cbd_front.sv
// front end: takes body bytes and classifies them for the back end
// depends on cbd_pkg
module cbd_front import cbd_pkg::*; (
  input  logic       push,
  output logic       full,
  input  logic [7:0] body_byte_i,
  input  logic       first_byte_i,
  input  logic       end_of_data_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cls_t       q_item_o
);

  logic is_dec, is_lower, is_upper;

  // handshake towards the class queue
  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  // hex digit decode
  assign is_dec   = (body_byte_i >= 8'd48) && (body_byte_i <= 8'd57);
  assign is_lower = (body_byte_i >= 8'd97) && (body_byte_i <= 8'd102);
  assign is_upper = (body_byte_i >= 8'd65) && (body_byte_i <= 8'd70);

  always_comb begin
    q_item_o.body_byte   = body_byte_i;
    q_item_o.first_byte  = first_byte_i;
    q_item_o.end_of_data = end_of_data_i;
    q_item_o.hex_ok      = is_dec || is_lower || is_upper;
    q_item_o.hex_val     = is_dec ? body_byte_i[3:0] : body_byte_i[3:0] + 4'd9;
    q_item_o.is_cr       = (body_byte_i == CH_CR);
    q_item_o.is_lf       = (body_byte_i == CH_LF);
    q_item_o.is_semi     = (body_byte_i == CH_SEMI);
  end

endmodule

>>> hw/rtl/cbd_back.sv
// back end: framing state machine, chunk size tracking and byte counters
// depends on cbd_pkg
module cbd_back import cbd_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_empty_i,
  input  cls_t in_item_i,
  output logic in_pop_o,
  input  logic out_full_i,
  output logic out_push_o,
  output res_t out_res_o
);

  // framing phases
  localparam logic [3:0] P_SIZE     = 4'd0;
  localparam logic [3:0] P_SIZE_LF  = 4'd1;
  localparam logic [3:0] P_EXT      = 4'd2;
  localparam logic [3:0] P_EXT_CR   = 4'd3;
  localparam logic [3:0] P_DATA     = 4'd4;
  localparam logic [3:0] P_DATA_CR  = 4'd5;
  localparam logic [3:0] P_DATA_LF  = 4'd6;
  localparam logic [3:0] P_TR_START = 4'd7;
  localparam logic [3:0] P_TR_LINE  = 4'd8;
  localparam logic [3:0] P_TR_CR    = 4'd9;
  localparam logic [3:0] P_TR_END   = 4'd10;
  localparam logic [3:0] P_DONE     = 4'd11;
  localparam logic [3:0] P_BAD      = 4'd12;
  localparam logic [3:0] P_BIG      = 4'd13;
  localparam logic [3:0] P_SHORT    = 4'd14;

  // status codes
  localparam logic [2:0] ST_BUSY  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_BIG   = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;

  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  function automatic logic [2:0] status_of(logic [3:0] p);
    logic [2:0] s;
    unique case (p)
      P_DONE:  s = ST_DONE;
      P_BAD:   s = ST_BAD;
      P_BIG:   s = ST_BIG;
      P_SHORT: s = ST_SHORT;
      default: s = ST_BUSY;
    endcase
    return s;
  endfunction

  logic [3:0]            phase_q, phase_d, ph;
  logic [31:0]           chunk_left_q, chunk_left_d, cl;
  logic                  saw_digit_q, saw_digit_d, sd;
  logic [COUNT_BITS-1:0] consumed_q, consumed_d, cons;
  logic [COUNT_BITS-1:0] decoded_q, decoded_d, dec;
  logic [35:0]           size_next;
  logic [7:0]            pb;
  logic                  pv;
  logic                  fire;
  logic [63:0]           cons_ext, dec_ext;

  // one request moves whenever a classified byte waits and a result slot is free
  assign fire       = !in_empty_i && !out_full_i;
  assign in_pop_o   = fire;
  assign out_push_o = fire;

  // first byte restart view of the state
  always_comb begin
    if (in_item_i.first_byte) begin
      ph   = P_SIZE;
      cl   = '0;
      sd   = 1'b0;
      cons = '0;
      dec  = '0;
    end else begin
      ph   = phase_q;
      cl   = chunk_left_q;
      sd   = saw_digit_q;
      cons = consumed_q;
      dec  = decoded_q;
    end
  end

  assign size_next = {cl, in_item_i.hex_val};

  // framing step for one byte
  always_comb begin
    phase_d      = ph;
    chunk_left_d = cl;
    saw_digit_d  = sd;
    consumed_d   = cons;
    decoded_d    = dec;
    pb           = 8'd0;
    pv           = 1'b0;
    if (status_of(ph) == ST_BUSY) begin
      consumed_d = cons + CNT_ONE;
      unique case (ph)
        P_SIZE: begin
          if (in_item_i.hex_ok) begin
            saw_digit_d = 1'b1;
            if (size_next > {4'd0, cfg_i.max_chunk}) begin
              phase_d = P_BIG;
            end else begin
              chunk_left_d = size_next[31:0];
            end
          end else if (!sd) begin
            phase_d = P_BAD;
          end else if (in_item_i.is_semi) begin
            phase_d = P_EXT;
          end else if (in_item_i.is_cr) begin
            phase_d = P_SIZE_LF;
          end else begin
            phase_d = P_BAD;
          end
        end
        P_SIZE_LF: begin
          if (in_item_i.is_lf) begin
            phase_d = (cl == '0) ? P_TR_START : P_DATA;
          end else begin
            phase_d = P_BAD;
          end
        end
        P_EXT: begin
          if (in_item_i.is_cr) phase_d = P_EXT_CR;
        end
        P_EXT_CR: begin
          if (in_item_i.is_lf) begin
            phase_d = (cl == '0) ? P_TR_START : P_DATA;
          end else if (!in_item_i.is_cr) begin
            phase_d = P_EXT;
          end
        end
        P_DATA: begin
          if (cl == '0) begin
            // data phase always opens with a nonzero size
            phase_d = in_item_i.is_cr ? P_DATA_LF : P_BAD;
          end else begin
            if (cfg_i.emit_payload) begin
              pb        = in_item_i.body_byte;
              pv        = 1'b1;
              decoded_d = dec + CNT_ONE;
            end
            chunk_left_d = cl - 32'd1;
            if (cl == 32'd1) phase_d = P_DATA_CR;
          end
        end
        P_DATA_CR: begin
          phase_d = in_item_i.is_cr ? P_DATA_LF : P_BAD;
        end
        P_DATA_LF: begin
          if (in_item_i.is_lf) begin
            phase_d      = P_SIZE;
            chunk_left_d = '0;
            saw_digit_d  = 1'b0;
          end else begin
            phase_d = P_BAD;
          end
        end
        P_TR_START: begin
          phase_d = in_item_i.is_cr ? P_TR_END : P_TR_LINE;
        end
        P_TR_LINE: begin
          if (in_item_i.is_cr) phase_d = P_TR_CR;
        end
        P_TR_CR: begin
          if (in_item_i.is_lf) begin
            phase_d = P_TR_START;
          end else if (!in_item_i.is_cr) begin
            phase_d = P_TR_LINE;
          end
        end
        P_TR_END: begin
          phase_d = in_item_i.is_lf ? P_DONE : P_BAD;
        end
        default: begin
          phase_d = P_BAD;
        end
      endcase
      // early end of input
      if (in_item_i.end_of_data && (status_of(phase_d) == ST_BUSY)) begin
        phase_d = P_SHORT;
      end
    end
  end

  // result request, counters reported in their low 32 bits
  assign cons_ext = 64'(consumed_d);
  assign dec_ext  = 64'(decoded_d);

  always_comb begin
    out_res_o.payload_byte  = pb;
    out_res_o.payload_valid = pv;
    out_res_o.status        = status_of(phase_d);
    out_res_o.raw_count     = cons_ext[31:0];
    out_res_o.decoded_count = dec_ext[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= P_SIZE;
      chunk_left_q <= '0;
      saw_digit_q  <= 1'b0;
      consumed_q   <= '0;
      decoded_q    <= '0;
    end else if (fire) begin
      phase_q      <= phase_d;
      chunk_left_q <= chunk_left_d;
      saw_digit_q  <= saw_digit_d;
      consumed_q   <= consumed_d;
      decoded_q    <= decoded_d;
    end
  end

  // data phase never holds an exhausted chunk
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_DATA) |-> (chunk_left_q != '0))
    else $error("data phase with zero bytes left");

  // payload only leaves in decode mode
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && out_res_o.payload_valid) |-> cfg_i.emit_payload)
    else $error("payload passed out in validate mode");

  // final status holds until the next first byte
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_item_i.first_byte && (status_of(phase_q) != ST_BUSY))
      |=> (phase_q == $past(phase_q)) && (consumed_q == $past(consumed_q)))
    else $error("final status left without restart");

  // a size digit only lands in the chunk counter while within the limit
  a_size_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (ph == P_SIZE) && in_item_i.hex_ok && (phase_d != P_BIG))
      |-> (chunk_left_d <= cfg_i.max_chunk))
    else $error("chunk size above limit accepted");

endmodule

>>> hw/rtl/chunked_body_deframer.sv
// top level of the chunked body deframer: configuration registers and the two queues
// depends on cbd_pkg, cbd_front, cbd_fifo, cbd_back

// Checks HTTP/1.1 chunked transfer coding one body byte per request and returns one
// result per byte: the decoded data byte (in decode mode), the framing status and the
// raw and decoded byte counts. The block sustains one byte per clock cycle when nothing
// stalls; a pushed byte is stored in the class queue, and when the back end fires,
// its result is written to the result queue, where it shows on the result ports and
// can be popped. That rate is set by the back end's state update, whose longest
// path is the size-digit shift-add and compare against max_chunk. A short queue sits
// between the classifying front end and the back end, and another holds results, so
// either side may stall without stopping the other. Configuration writes are always
// taken (ready is tied high) and must only happen while the block is idle.
module chunked_body_deframer import cbd_pkg::*; #(
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  body_byte_i,
  input  logic        first_byte_i,
  input  logic        end_of_data_i,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] raw_count_o,
  output logic [31:0] decoded_count_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] max_chunk_q;
  logic        emit_payload_q;
  cfg_t        cfg;
  logic        cls_push, cls_full, cls_pop, cls_empty;
  cls_t        cls_in, cls_out;
  logic        res_push, res_full;
  res_t        res_in, res_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q    <= MAX_CHUNK_RESET;
      emit_payload_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_CHUNK: max_chunk_q    <= cfg_data_i;
        CFG_EMIT:      emit_payload_q <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg.max_chunk    = max_chunk_q;
  assign cfg.emit_payload = emit_payload_q;

  // front end: accept and classify
  cbd_front u_front (
    .push          (push),
    .full          (full),
    .body_byte_i   (body_byte_i),
    .first_byte_i  (first_byte_i),
    .end_of_data_i (end_of_data_i),
    .q_full_i      (cls_full),
    .q_push_o      (cls_push),
    .q_item_o      (cls_in)
  );

  // queue of classified bytes
  cbd_fifo #(
    .WIDTH (CLS_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cls_push),
    .data_i  (cls_in),
    .full_o  (cls_full),
    .pop_i   (cls_pop),
    .data_o  (cls_out),
    .empty_o (cls_empty)
  );

  // back end: framing state machine
  cbd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_empty_i (cls_empty),
    .in_item_i  (cls_out),
    .in_pop_o   (cls_pop),
    .out_full_i (res_full),
    .out_push_o (res_push),
    .out_res_o  (res_in)
  );

  // result queue
  cbd_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign payload_byte_o  = res_out.payload_byte;
  assign payload_valid_o = res_out.payload_valid;
  assign status_o        = res_out.status;
  assign raw_count_o     = res_out.raw_count;
  assign decoded_count_o = res_out.decoded_count;

endmodule
